/* design/spfr_pkg.sv */
// ----------------------------------------------------------------------------
// spfr_pkg
// Shared types and constants of the servo position command framer.
// ----------------------------------------------------------------------------
package spfr_pkg;

    // Field and datapath widths.
    localparam int ANGLE_W  = 16;
    localparam int MAXSPD_W = 18;
    localparam int GAIN_W   = 11;
    localparam int CFG_W    = 18;
    localparam int MCAND_W  = 18;          // 3 * |angle change|
    localparam int PROD_W   = 30;          // 3 * |change| * gain, padded to whole digits
    localparam int CODE_W   = 20;          // (target + 18000) * 6 fits signed 20 bits
    localparam int SPD_W    = 32;
    localparam int IDX_W    = 5;

    // Serial unit step counts: two bits per step.
    localparam int MUL_STEPS = 6;
    localparam int DIV_STEPS = 15;
    localparam int MUL_CNT_W = 3;
    localparam int DIV_CNT_W = 4;

    // Angle offset added before scaling into the angle code.
    localparam logic [CODE_W-1:0] ANGLE_OFFSET = CODE_W'(18000);

    // Divisor left after folding 60/100 into 3/5.
    localparam logic [4:0] DIVISOR = 5'd5;

    // Configuration register indexes.
    localparam logic CFG_MAX_SPEED = 1'b0;
    localparam logic CFG_GAIN      = 1'b1;

    // Frame layout.
    localparam logic [IDX_W-1:0] FRAME_LEN    = 5'd18;
    localparam logic [IDX_W-1:0] BYTE_SYNC0   = 5'd0;
    localparam logic [IDX_W-1:0] BYTE_SYNC1   = 5'd1;
    localparam logic [IDX_W-1:0] BYTE_ID      = 5'd2;
    localparam logic [IDX_W-1:0] BYTE_LEN     = 5'd3;
    localparam logic [IDX_W-1:0] BYTE_HDR_SUM = 5'd4;
    localparam logic [IDX_W-1:0] BYTE_CODE0   = 5'd5;
    localparam logic [IDX_W-1:0] BYTE_SPD0    = 5'd13;
    localparam logic [IDX_W-1:0] BYTE_SUM     = 5'd17;

    localparam logic [7:0] SYNC0   = 8'h3E;
    localparam logic [7:0] SYNC1   = 8'hA4;
    localparam logic [7:0] DEV_ID  = 8'h01;
    localparam logic [7:0] DATA_LEN = 8'h0C;
    localparam logic [7:0] HDR_SUM = SYNC0 + SYNC1 + DEV_ID + DATA_LEN;

    // Status of a serial arithmetic unit.
    typedef struct packed {
        logic busy;
        logic done;
    } t_unit_sts;

    // Speed calculation sequencer.
    typedef enum logic [1:0] {
        CALC_IDLE,
        CALC_MUL,
        CALC_DIV,
        CALC_READY
    } t_calc_state;

endpackage

/* design/spfr_mul.sv */
// ----------------------------------------------------------------------------
// spfr_mul
// Serial multiplier: scans the gain two bits per cycle, most significant first.
// ----------------------------------------------------------------------------
module spfr_mul (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [spfr_pkg::MCAND_W-1:0]  i_mcand,
    input  logic [spfr_pkg::GAIN_W-1:0]   i_gain,
    output spfr_pkg::t_unit_sts           o_sts,
    output logic [spfr_pkg::PROD_W-1:0]   o_product
);
    import spfr_pkg::*;

    localparam int GSR_W = 2 * MUL_STEPS;

    logic                 r_busy;
    logic                 r_done;
    logic [MUL_CNT_W-1:0] r_cnt;
    logic [GSR_W-1:0]     r_gain_sr;
    logic [MCAND_W-1:0]   r_mcand;
    logic [PROD_W-1:0]    r_acc;
    logic [1:0]           digit;
    logic [PROD_W-1:0]    partial;

    // Partial product of the multiplicand and one two-bit gain digit.
    always_comb begin
        digit   = r_gain_sr[GSR_W-1 -: 2];
        partial = ({{(PROD_W-MCAND_W){1'b0}}, r_mcand} & {PROD_W{digit[0]}})
                + ({{(PROD_W-MCAND_W-1){1'b0}}, r_mcand, 1'b0} & {PROD_W{digit[1]}});
    end

    // Control of the step sequence.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == MUL_CNT_W'(MUL_STEPS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Shift-and-add datapath.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_acc     <= '0;
            r_mcand   <= i_mcand;
            r_gain_sr <= {{(GSR_W-GAIN_W){1'b0}}, i_gain};
        end else if (r_busy) begin
            r_acc     <= {r_acc[PROD_W-3:0], 2'b00} + partial;
            r_gain_sr <= {r_gain_sr[GSR_W-3:0], 2'b00};
        end
    end

    assign o_sts.busy = r_busy;
    assign o_sts.done = r_done;
    assign o_product  = r_acc;

endmodule

/* design/spfr_div5.sv */
// ----------------------------------------------------------------------------
// spfr_div5
// Serial divider by five: two quotient bits per cycle, most significant first.
// ----------------------------------------------------------------------------
module spfr_div5 (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [spfr_pkg::PROD_W-1:0]   i_dividend,
    output spfr_pkg::t_unit_sts           o_sts,
    output logic [spfr_pkg::PROD_W-1:0]   o_quotient
);
    import spfr_pkg::*;

    logic                 r_busy;
    logic                 r_done;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic [PROD_W-1:0]    r_sr;
    logic [2:0]           r_rem;
    logic [4:0]           part;
    logic [1:0]           q_digit;
    logic [4:0]           part_rem;

    // The partial remainder stays below 20, so the digit is a small compare.
    always_comb begin
        part = {r_rem, r_sr[PROD_W-1 -: 2]};
        if (part >= 3 * DIVISOR) begin
            q_digit = 2'd3;
        end else if (part >= 2 * DIVISOR) begin
            q_digit = 2'd2;
        end else if (part >= DIVISOR) begin
            q_digit = 2'd1;
        end else begin
            q_digit = 2'd0;
        end
        part_rem = part - 5'(DIVISOR * q_digit);
    end

    // Control of the step sequence.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == DIV_CNT_W'(DIV_STEPS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Dividend bits leave at the top while quotient digits enter at the bottom.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_sr  <= i_dividend;
            r_rem <= '0;
        end else if (r_busy) begin
            r_sr  <= {r_sr[PROD_W-3:0], q_digit};
            r_rem <= part_rem[2:0];
        end
    end

    assign o_sts.busy = r_busy;
    assign o_sts.done = r_done;
    assign o_quotient = r_sr;

endmodule

/* design/servo_position_command_framer_core.sv */
// ----------------------------------------------------------------------------
// servo_position_command_framer_core
// Turns each target angle into an 18-byte position command frame.
// ----------------------------------------------------------------------------
//
//   Channel  | Direction | Handshake           | Payload
//   ---------+-----------+---------------------+------------------------------
//   input    | in        | i_valid / o_stall   | i_angle_target
//   output   | out       | o_valid / i_stall   | o_frame_byte, o_last_byte
//   config   | in        | i_cfg_we            | i_cfg_index, i_cfg_data
//
// The speed goes through a serial multiplier (6 steps) and a serial divide by
// five (15 steps); it is ready once the divider is done. The header and angle
// bytes are sent meanwhile and the five last bytes follow, so the next item
// can be accepted only after the last byte of the frame has been taken.
// o_stall stays high from the accepted item until its last byte is taken.
// Reset is synchronous and clears the previous angle and both registers.
// Output stalls hold the current byte and pause the frame.
module servo_position_command_framer_core (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    output logic                           o_stall,
    input  logic [spfr_pkg::ANGLE_W-1:0]   i_angle_target,
    output logic                           o_valid,
    input  logic                           i_stall,
    output logic [7:0]                     o_frame_byte,
    output logic                           o_last_byte,
    input  logic                           i_cfg_we,
    input  logic                           i_cfg_index,
    input  logic [spfr_pkg::CFG_W-1:0]     i_cfg_data
);
    import spfr_pkg::*;

    // Registers and state.
    logic [MAXSPD_W-1:0] r_max_speed;
    logic [GAIN_W-1:0]   r_gain;
    logic [ANGLE_W-1:0]  r_prev_angle;
    t_calc_state         r_state;
    t_calc_state         n_state;
    logic [IDX_W-1:0]    r_idx;
    logic [CODE_W-1:0]   r_code_sr;
    logic [SPD_W-1:0]    r_spd_sr;
    logic [7:0]          r_sum;
    logic                r_o_valid;
    logic [7:0]          r_o_byte;
    logic                r_o_last;

    logic                in_accept;
    logic                out_accept;
    logic                frame_done;
    logic                mul_start;
    logic                div_start;
    logic [ANGLE_W:0]    diff;
    logic [ANGLE_W:0]    diff_abs;
    logic [MCAND_W-1:0]  mag3;
    logic [CODE_W-1:0]   shifted;
    logic [CODE_W-1:0]   code;
    logic [PROD_W-1:0]   product;
    logic [PROD_W-1:0]   quotient;
    logic [SPD_W-1:0]    spd_sel;
    t_unit_sts           mul_sts;
    t_unit_sts           div_sts;
    logic                load;
    logic [7:0]          next_byte;

    assign in_accept  = i_valid && !o_stall;
    assign out_accept = r_o_valid && !i_stall;
    assign frame_done = out_accept && r_o_last;
    assign o_stall    = (r_state != CALC_IDLE);

    // Configuration writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_speed <= '0;
            r_gain      <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_MAX_SPEED: r_max_speed <= i_cfg_data[MAXSPD_W-1:0];
                CFG_GAIN:      r_gain      <= i_cfg_data[GAIN_W-1:0];
                default:       r_gain      <= r_gain;
            endcase
        end
    end

    // Angle change scaled by three, and the angle code (x*6 as 4x + 2x).
    always_comb begin
        diff     = {r_prev_angle[ANGLE_W-1], r_prev_angle}
                 - {i_angle_target[ANGLE_W-1], i_angle_target};
        diff_abs = diff[ANGLE_W] ? (~diff + 1'b1) : diff;
        mag3     = {2'b00, diff_abs[ANGLE_W-1:0]} + {1'b0, diff_abs[ANGLE_W-1:0], 1'b0};
        shifted  = {{(CODE_W-ANGLE_W){i_angle_target[ANGLE_W-1]}}, i_angle_target}
                 + ANGLE_OFFSET;
        code     = {shifted[CODE_W-3:0], 2'b00} + {shifted[CODE_W-2:0], 1'b0};
    end

    // Previous target.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_angle <= '0;
        end else if (in_accept) begin
            r_prev_angle <= i_angle_target;
        end
    end

    spfr_mul u_mul (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (mul_start),
        .i_mcand   (mag3),
        .i_gain    (r_gain),
        .o_sts     (mul_sts),
        .o_product (product)
    );

    spfr_div5 u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (product),
        .o_sts      (div_sts),
        .o_quotient (quotient)
    );

    // Sequencer next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            CALC_IDLE:  if (in_accept)    n_state = CALC_MUL;
            CALC_MUL:   if (mul_sts.done) n_state = CALC_DIV;
            CALC_DIV:   if (div_sts.done) n_state = CALC_READY;
            CALC_READY: if (frame_done)   n_state = CALC_IDLE;
            default:                      n_state = CALC_IDLE;
        endcase
    end

    // Sequencer outputs.
    always_comb begin
        mul_start = 1'b0;
        div_start = 1'b0;
        case (r_state)
            CALC_IDLE: mul_start = in_accept;
            CALC_MUL:  div_start = mul_sts.done;
            default: begin
                mul_start = 1'b0;
                div_start = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= CALC_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // A nonzero change-based speed below the limit replaces it.
    always_comb begin
        if ((quotient != '0) && (quotient < {{(PROD_W-MAXSPD_W){1'b0}}, r_max_speed})) begin
            spd_sel = {{(SPD_W-PROD_W){1'b0}}, quotient};
        end else begin
            spd_sel = {{(SPD_W-MAXSPD_W){1'b0}}, r_max_speed};
        end
    end

    // Byte of the frame at the current position.
    always_comb begin
        case (r_idx)
            BYTE_SYNC0:   next_byte = SYNC0;
            BYTE_SYNC1:   next_byte = SYNC1;
            BYTE_ID:      next_byte = DEV_ID;
            BYTE_LEN:     next_byte = DATA_LEN;
            BYTE_HDR_SUM: next_byte = HDR_SUM;
            BYTE_SUM:     next_byte = r_sum;
            default:      next_byte = (r_idx < BYTE_SPD0) ? r_code_sr[7:0] : r_spd_sr[7:0];
        endcase
    end

    // The speed bytes wait until the divider has finished.
    assign load = (r_state != CALC_IDLE) && (r_idx != FRAME_LEN)
               && ((r_idx < BYTE_SPD0) || (r_state == CALC_READY))
               && (!r_o_valid || !i_stall);

    // Frame position and output register control.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx     <= '0;
            r_o_valid <= 1'b0;
        end else begin
            if (in_accept) begin
                r_idx <= '0;
            end else if (load) begin
                r_idx <= r_idx + 1'b1;
            end
            if (load) begin
                r_o_valid <= 1'b1;
            end else if (out_accept) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    // Payload shift registers, data sum and output byte.
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_code_sr <= code;
            r_sum     <= '0;
        end else if (load && (r_idx >= BYTE_CODE0) && (r_idx < BYTE_SPD0)) begin
            r_code_sr <= {{8{r_code_sr[CODE_W-1]}}, r_code_sr[CODE_W-1:8]};
            r_sum     <= r_sum + r_code_sr[7:0];
        end else if (load && (r_idx >= BYTE_SPD0) && (r_idx < BYTE_SUM)) begin
            r_sum     <= r_sum + r_spd_sr[7:0];
        end

        if (div_sts.done) begin
            r_spd_sr <= spd_sel;
        end else if (load && (r_idx >= BYTE_SPD0) && (r_idx < BYTE_SUM)) begin
            r_spd_sr <= {8'h00, r_spd_sr[SPD_W-1:8]};
        end

        if (load) begin
            r_o_byte <= next_byte;
            r_o_last <= (r_idx == BYTE_SUM);
        end
    end

    assign o_valid      = r_o_valid;
    assign o_frame_byte = r_o_byte;
    assign o_last_byte  = r_o_last;

endmodule

/* design/spfr_checker.sv */
// ----------------------------------------------------------------------------
// spfr_checker
// Port-level checks of the framer, attached to the top level by bind.
// ----------------------------------------------------------------------------
module spfr_checker (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           i_valid,
    input logic                           o_stall,
    input logic                           o_valid,
    input logic                           i_stall,
    input logic [7:0]                     o_frame_byte,
    input logic                           o_last_byte
);
    import spfr_pkg::*;

    // Every frame opens with the first sync byte, registered after its item is accepted.
    a_frame_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |-> ##2 (o_valid && (o_frame_byte == SYNC0)))
        else $error("frame did not start with the sync byte");

    // A new item is held off while its frame is under way.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> o_stall)
        else $error("input not stalled after an accepted item");

    // Output bytes appear only while an item is in progress.
    a_out_in_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_stall)
        else $error("output byte outside of a frame");

    // Nothing follows the final byte until a new item arrives.
    a_gap_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_stall && o_last_byte) |=> (!o_valid && !o_stall))
        else $error("output continued after the last byte");

    // A stalled byte holds.
    a_hold_stalled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_frame_byte) && $stable(o_last_byte)))
        else $error("stalled output byte changed");

endmodule

bind servo_position_command_framer_core spfr_checker u_spfr_checker (.*);
